[design/htcl_pkg.sv]
// Shared types and constants for the Huffman total code length block.
// Used by htcl_cell, htcl_ctrl, huffman_total_code_length and its checker.
package htcl_pkg;

    // Set capacity and weight width
    localparam int MAX_SYMBOLS = 256;
    localparam int WEIGHT_BITS = 16;

    // Fixed field widths of the request channels
    localparam int SYM_WEIGHT_BITS = 16;
    localparam int TOTAL_BITS      = 40;
    localparam int SYM_COUNT_BITS  = 9;

    // Derived widths: a merged node holds up to MAX_SYMBOLS full weights
    localparam int NODE_BITS  = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int COUNT_BITS = $clog2(MAX_SYMBOLS + 1);
    localparam int ACC_BITS   = ((NODE_BITS > TOTAL_BITS) ? NODE_BITS : TOTAL_BITS) + 1;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef logic [NODE_BITS-1:0]  node_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [SYM_WEIGHT_BITS-1:0] symbol_weight;
        logic                       last_symbol;
    } sym_req_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0]     total_bits;
        logic [SYM_COUNT_BITS-1:0] symbol_count;
        logic                      overflow;
    } res_req_t;

    // Operation broadcast to every cell of the sorted chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        node_t    value;
    } chain_cmd_t;

    // What a cell hands to its right neighbor
    typedef struct packed {
        node_t value;
        logic  displaced;
    } cell_link_t;

endpackage

[design/huffman_total_code_length.sv]
// After the request marked last, the sequencer runs n-1 merges for n symbols
// held, each a pop, pop and sorted insert through the cell chain, then the
// result sits in the output register. Throughput: one weight request per cycle
// while loading. No request is taken during merging. Reset (rst_n, async,
// active low) empties the set and output.
// Top level: sorted chain of weight cells plus the sequencer; depends on htcl_pkg.
module huffman_total_code_length (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_ready,
    input  htcl_pkg::sym_req_t sym,
    output logic               res_valid,
    input  logic               res_ready,
    output htcl_pkg::res_req_t res
);

    htcl_pkg::chain_cmd_t cmd;
    htcl_pkg::count_t     count;
    htcl_pkg::cell_link_t link [htcl_pkg::MAX_SYMBOLS];

    htcl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym        (sym),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .head_value (link[0].value),
        .count      (count),
        .cmd        (cmd)
    );

    // Build the chain; cells below the count are occupied
    for (genvar i = 0; i < htcl_pkg::MAX_SYMBOLS; i++)
    begin : g_cell
        htcl_pkg::cell_link_t left;
        htcl_pkg::node_t      right_value;
        logic                 occupied;

        assign occupied = (htcl_pkg::count_t'(i) < count);

        if (i == 0)
        begin : g_first
            assign left.value     = '0;
            assign left.displaced = 1'b0;
        end
        else
        begin : g_inner
            assign left = link[i-1];
        end

        if (i == htcl_pkg::MAX_SYMBOLS - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_body
            assign right_value = link[i+1].value;
        end

        htcl_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occupied),
            .left        (left),
            .right_value (right_value),
            .link        (link[i])
        );
    end

endmodule

[design/htcl_cell.sv]
// One cell of the sorted weight chain: holds one weight, kept in ascending order.
// Depends on htcl_pkg for node, command and link types.
module htcl_cell (
    input  logic                clk,
    input  htcl_pkg::chain_cmd_t cmd,
    input  logic                occupied,
    input  htcl_pkg::cell_link_t left,
    input  htcl_pkg::node_t      right_value,
    output htcl_pkg::cell_link_t link
);

    htcl_pkg::node_t value_reg;
    htcl_pkg::node_t value_next;
    logic            displaced;

    // An empty cell counts as larger than any weight
    assign displaced = !occupied || (cmd.value < value_reg);

    // Insert takes the new weight or the left neighbor's; shift pulls from the right
    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            htcl_pkg::OP_INSERT:
            begin
                if (displaced)
                begin
                    value_next = left.displaced ? left.value : cmd.value;
                end
            end
            htcl_pkg::OP_SHIFT:
            begin
                value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value     = value_reg;
    assign link.displaced = displaced;

endmodule

[design/htcl_ctrl.sv]
// Sequencer: loads weights, runs the pop-pop-push merge loop, holds the result.
// Depends on htcl_pkg; drives the cell chain through a chain_cmd_t.
module htcl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_ready,
    input  htcl_pkg::sym_req_t   sym,
    output logic                 res_valid,
    input  logic                 res_ready,
    output htcl_pkg::res_req_t   res,
    input  htcl_pkg::node_t      head_value,
    output htcl_pkg::count_t     count,
    output htcl_pkg::chain_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_POP_A = 5'b00010,
        S_POP_B = 5'b00100,
        S_PUSH  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    htcl_pkg::count_t                 count_reg, count_next;
    htcl_pkg::count_t                 accepted_reg, accepted_next;
    logic [htcl_pkg::TOTAL_BITS-1:0]  total_reg, total_next;
    logic                             dropped_reg, dropped_next;
    htcl_pkg::node_t                  first_reg, first_next;
    htcl_pkg::node_t                  merged_reg, merged_next;
    logic                             res_valid_reg, res_valid_next;
    htcl_pkg::res_req_t               res_reg, res_next;
    logic [htcl_pkg::ACC_BITS-1:0]    total_sum;
    logic                             has_room;
    logic                             sym_fire;

    assign has_room  = (count_reg < htcl_pkg::count_t'(htcl_pkg::MAX_SYMBOLS));
    assign sym_ready = (state_reg == S_LOAD);
    assign sym_fire  = sym_valid && sym_ready;
    assign total_sum = htcl_pkg::ACC_BITS'(total_reg) + htcl_pkg::ACC_BITS'(merged_reg);

    // Sequence the load and merge phases
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        accepted_next  = accepted_reg;
        total_next     = total_reg;
        dropped_next   = dropped_reg;
        first_next     = first_reg;
        merged_next    = merged_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        cmd.op         = htcl_pkg::OP_HOLD;
        cmd.value      = merged_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                cmd.value = htcl_pkg::node_t'(sym.symbol_weight[htcl_pkg::WEIGHT_BITS-1:0]);
                if (sym_fire)
                begin
                    if (has_room)
                    begin
                        cmd.op     = htcl_pkg::OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (sym.last_symbol)
                    begin
                        accepted_next = has_room ? count_reg + 1'b1 : count_reg;
                        state_next    = S_POP_A;
                    end
                end
            end
            S_POP_A:
            begin
                if (count_reg > htcl_pkg::count_t'(1))
                begin
                    cmd.op     = htcl_pkg::OP_SHIFT;
                    first_next = head_value;
                    count_next = count_reg - 1'b1;
                    state_next = S_POP_B;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_B:
            begin
                cmd.op      = htcl_pkg::OP_SHIFT;
                merged_next = first_reg + head_value;
                count_next  = count_reg - 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = htcl_pkg::OP_INSERT;
                count_next = count_reg + 1'b1;
                if (total_sum > htcl_pkg::ACC_BITS'(htcl_pkg::TOTAL_MAX))
                begin
                    total_next = htcl_pkg::TOTAL_MAX;
                end
                else
                begin
                    total_next = total_sum[htcl_pkg::TOTAL_BITS-1:0];
                end
                state_next = S_POP_A;
            end
            S_DONE:
            begin
                // Wait for the output slot, then start a new set
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.total_bits   = total_reg;
                    res_next.symbol_count = htcl_pkg::SYM_COUNT_BITS'(accepted_reg);
                    res_next.overflow     = dropped_reg;
                    count_next            = '0;
                    total_next            = '0;
                    dropped_next          = 1'b0;
                    state_next            = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        first_reg    <= first_next;
        merged_reg   <= merged_next;
        res_reg      <= res_next;
    end

    assign count     = count_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/htcl_checker.sv]
// Port-level checks for huffman_total_code_length, attached by bind.
// Depends on htcl_pkg for request types and capacity.
module htcl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sym_valid,
    input logic               sym_ready,
    input htcl_pkg::sym_req_t sym,
    input logic               res_valid,
    input logic               res_ready,
    input htcl_pkg::res_req_t res
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Drop intake after the last request of a set
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && sym.last_symbol |=> !sym_ready)
        else $error("request taken right after last symbol");

    // Flag overflow only for a full set
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow |->
            res.symbol_count == htcl_pkg::SYM_COUNT_BITS'(htcl_pkg::MAX_SYMBOLS))
        else $error("overflow without a full set");

    // Report zero for an empty or single-symbol set
    a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (htcl_pkg::MAX_SYMBOLS < 512) && (res.symbol_count < 9'd2) |->
            res.total_bits == '0)
        else $error("nonzero total for trivial set");

endmodule

bind huffman_total_code_length htcl_checker u_htcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
